[hw/rtl/subharmonic_bass_synth_top_macros.svh]
// Assertion macros for the subharmonic bass synthesizer.
// Used by the top level; depends on nothing else.
`ifndef SUBHARMONIC_BASS_SYNTH_TOP_MACROS_SVH
`define SUBHARMONIC_BASS_SYNTH_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define SBS_ASSERT_IMPLY(name, clock, reset, cond, expr, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the condition.
`define SBS_ASSERT_NEXT(name, clock, reset, cond, expr, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error(msg);

`endif

[hw/rtl/sbs_pkg.sv]
// Shared types and constants of the subharmonic bass synthesizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package sbs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS = SAMPLE_BITS - 1;
  localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_COEFF = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OSC_STEP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY        = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WET_LEVEL    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRY_LEVEL    = 3'd6;

  typedef enum logic [1:0] {
    MODE_DISTORT,
    MODE_DIVIDE,
    MODE_INVERT,
    MODE_OSC
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] filter_coeff;
    logic [17:0] osc_step;
    logic [23:0] threshold;
    logic [23:0] decay;
    logic [15:0] wet_level;
    logic [15:0] dry_level;
  } cfg_t;

  localparam logic [15:0] RST_FILTER_COEFF = 16'd1039;
  localparam logic [17:0] RST_OSC_STEP     = 18'd30580;
  localparam logic [23:0] RST_THRESHOLD    = 24'd529300;
  localparam logic [23:0] RST_DECAY        = 24'd16775334;
  localparam logic [15:0] RST_WET_LEVEL    = 16'd9830;
  localparam logic [15:0] RST_DRY_LEVEL    = 16'd32768;

  // Shared multiplier operand widths.
  localparam int OPA_BITS = 34;
  localparam int OPB_BITS = 25;
  localparam int PROD_BITS = OPA_BITS + OPB_BITS;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_P1_MUL,
    OP_P1_WB,
    OP_P2_MUL,
    OP_P2_WB,
    OP_CLIP,
    OP_ENV_MUL,
    OP_ENV_WB,
    OP_SIN_MUL,
    OP_SIN_WB,
    OP_Q1_MUL,
    OP_Q1_WB,
    OP_Q2_MUL,
    OP_Q2_WB,
    OP_ML_DRY,
    OP_ML_WET,
    OP_ML_WB,
    OP_MR_DRY,
    OP_MR_WET,
    OP_MR_WB
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P1_MUL,
    ST_P1_WB,
    ST_P2_MUL,
    ST_P2_WB,
    ST_CLIP,
    ST_ENV_MUL,
    ST_ENV_WB,
    ST_SIN_MUL,
    ST_SIN_WB,
    ST_Q1_MUL,
    ST_Q1_WB,
    ST_Q2_MUL,
    ST_Q2_WB,
    ST_ML_DRY,
    ST_ML_WET,
    ST_ML_WB,
    ST_MR_DRY,
    ST_MR_WET,
    ST_MR_WB
  } state_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic osc_mode;
    logic out_busy;
  } stat_t;

endpackage

[hw/rtl/sbs_ctrl.sv]
// Sequencing state machine of the subharmonic bass synthesizer.
// Depends on sbs_pkg; drives one datapath command per cycle.
module sbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  sbs_pkg::stat_t stat,
  output sbs_pkg::op_t   op,
  output logic           idle
);

  sbs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = sbs_pkg::OP_NONE;
    idle = 1'b0;
    case (state)
      sbs_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          op = sbs_pkg::OP_LOAD;
          state_next = sbs_pkg::ST_P1_MUL;
        end
      end
      sbs_pkg::ST_P1_MUL: begin
        op = sbs_pkg::OP_P1_MUL;
        state_next = sbs_pkg::ST_P1_WB;
      end
      sbs_pkg::ST_P1_WB: begin
        op = sbs_pkg::OP_P1_WB;
        state_next = sbs_pkg::ST_P2_MUL;
      end
      sbs_pkg::ST_P2_MUL: begin
        op = sbs_pkg::OP_P2_MUL;
        state_next = sbs_pkg::ST_P2_WB;
      end
      sbs_pkg::ST_P2_WB: begin
        op = sbs_pkg::OP_P2_WB;
        state_next = stat.osc_mode ? sbs_pkg::ST_ENV_MUL : sbs_pkg::ST_CLIP;
      end
      sbs_pkg::ST_CLIP: begin
        op = sbs_pkg::OP_CLIP;
        state_next = sbs_pkg::ST_Q1_MUL;
      end
      sbs_pkg::ST_ENV_MUL: begin
        op = sbs_pkg::OP_ENV_MUL;
        state_next = sbs_pkg::ST_ENV_WB;
      end
      sbs_pkg::ST_ENV_WB: begin
        op = sbs_pkg::OP_ENV_WB;
        state_next = sbs_pkg::ST_SIN_MUL;
      end
      sbs_pkg::ST_SIN_MUL: begin
        op = sbs_pkg::OP_SIN_MUL;
        state_next = sbs_pkg::ST_SIN_WB;
      end
      sbs_pkg::ST_SIN_WB: begin
        op = sbs_pkg::OP_SIN_WB;
        state_next = sbs_pkg::ST_Q1_MUL;
      end
      sbs_pkg::ST_Q1_MUL: begin
        op = sbs_pkg::OP_Q1_MUL;
        state_next = sbs_pkg::ST_Q1_WB;
      end
      sbs_pkg::ST_Q1_WB: begin
        op = sbs_pkg::OP_Q1_WB;
        state_next = sbs_pkg::ST_Q2_MUL;
      end
      sbs_pkg::ST_Q2_MUL: begin
        op = sbs_pkg::OP_Q2_MUL;
        state_next = sbs_pkg::ST_Q2_WB;
      end
      sbs_pkg::ST_Q2_WB: begin
        op = sbs_pkg::OP_Q2_WB;
        state_next = sbs_pkg::ST_ML_DRY;
      end
      sbs_pkg::ST_ML_DRY: begin
        op = sbs_pkg::OP_ML_DRY;
        state_next = sbs_pkg::ST_ML_WET;
      end
      sbs_pkg::ST_ML_WET: begin
        op = sbs_pkg::OP_ML_WET;
        state_next = sbs_pkg::ST_ML_WB;
      end
      sbs_pkg::ST_ML_WB: begin
        op = sbs_pkg::OP_ML_WB;
        state_next = sbs_pkg::ST_MR_DRY;
      end
      sbs_pkg::ST_MR_DRY: begin
        op = sbs_pkg::OP_MR_DRY;
        state_next = sbs_pkg::ST_MR_WET;
      end
      sbs_pkg::ST_MR_WET: begin
        op = sbs_pkg::OP_MR_WET;
        state_next = sbs_pkg::ST_MR_WB;
      end
      sbs_pkg::ST_MR_WB: begin
        // Hold the finished products until the output register has room.
        if (!stat.out_busy) begin
          op = sbs_pkg::OP_MR_WB;
          state_next = sbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sbs_datapath.sv]
// Datapath of the subharmonic bass synthesizer: filter and oscillator state,
// one shared multiplier, the quarter-wave sine ROM and the output register.
// Depends on sbs_pkg; commanded by sbs_ctrl.
module sbs_datapath #(
  parameter int SINE_TABLE_DEPTH = sbs_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  sbs_pkg::op_t   op,
  input  sbs_pkg::cfg_t  cfg,
  input  sbs_pkg::in_t   in_data,
  input  logic           out_stall,
  output logic           out_valid,
  output sbs_pkg::out_t  out_data,
  output sbs_pkg::stat_t stat
);

  localparam int SB_W = sbs_pkg::SAMPLE_BITS;
  localparam int OPA_W = sbs_pkg::OPA_BITS;
  localparam int OPB_W = sbs_pkg::OPB_BITS;
  localparam int PROD_W = sbs_pkg::PROD_BITS;
  localparam int SUM_W = PROD_W + 1;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PHASE_W = 22;
  localparam int KPROD_W = PHASE_W + IDX_W;
  localparam int SIN_SHIFT = 54 - sbs_pkg::FRAC_BITS;
  localparam logic signed [OPA_W-1:0] UNITY = OPA_W'(64'sd1 <<< sbs_pkg::FRAC_BITS);

  typedef logic signed [31:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  // Quarter-wave sine in Q30: odd degree-9 polynomial evaluated by Horner steps.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint x;
    longint x2;
    longint r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (longint'(k) <<< 30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >>> 30;
      r = 172272;
      r = -5026995 + ((r * x2) >>> 30);
      r = 85569305 + ((r * x2) >>> 30);
      r = -693598668 + ((r * x2) >>> 30);
      r = 1686629713 + ((r * x2) >>> 30);
      rom[k] = 32'((r * x) >>> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // One-pole update: y plus the rounded, scaled difference, saturated to 32 bits.
  function automatic logic signed [31:0] pole_update(logic signed [31:0] y,
                                                     logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [SUM_W-1:0] s;
    t = (p + PROD_W'(32768)) >>> 16;
    s = SUM_W'(y) + SUM_W'(t);
    if (&s[SUM_W-1:31] || ~|s[SUM_W-1:31]) begin
      pole_update = s[31:0];
    end else begin
      pole_update = {s[SUM_W-1], {31{~s[SUM_W-1]}}};
    end
  endfunction

  // Output mix: dry and wet products, rounded to the sample grid and saturated.
  function automatic logic signed [SB_W-1:0] mix_sat(logic signed [PROD_W-1:0] d,
                                                     logic signed [PROD_W-1:0] w);
    logic signed [SUM_W-1:0] v;
    v = (SUM_W'(d) + SUM_W'(w) + SUM_W'(16384)) >>> 15;
    if (&v[SUM_W-1:SB_W-1] || ~|v[SUM_W-1:SB_W-1]) begin
      mix_sat = v[SB_W-1:0];
    end else begin
      mix_sat = {v[SUM_W-1], {(SB_W-1){~v[SUM_W-1]}}};
    end
  endfunction

  logic signed [SB_W-1:0]   a_s, b_s, left_res;
  logic signed [31:0]       pre1, pre2, post1, post2;
  logic                     div_sign, div_phase;
  logic [23:0]              osc_angle, envelope;
  logic signed [OPA_W-1:0]  sub, sub_clip, clip_val, dbl, thr_s, pre2_w;
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic                     mul_en;
  logic signed [PROD_W-1:0] mul, prod, acc, sin_shifted;
  logic                     gt, lt, flip, sign_new, phase_new;
  logic [KPROD_W-1:0]       kprod;
  logic [IDX_W-1:0]         kraw, k_sel, sine_idx;
  logic signed [31:0]       sine_word;

  assign stat.osc_mode = (cfg.mode == sbs_pkg::MODE_OSC);
  assign stat.out_busy = out_valid && out_stall;

  // Clip levels and the octave divider.
  assign thr_s = OPA_W'(cfg.threshold);
  assign pre2_w = OPA_W'(pre2);
  assign gt = pre2_w > thr_s;
  assign lt = pre2_w < -thr_s;
  assign flip = (gt || lt) && ((!gt && lt) != div_sign);
  assign sign_new = div_sign ^ flip;
  assign phase_new = div_phase ^ (flip && sign_new);
  assign clip_val = gt ? UNITY : (lt ? -UNITY : '0);
  assign dbl = pre2_w <<< 1;

  always_comb begin
    case (cfg.mode)
      sbs_pkg::MODE_DIVIDE: sub_clip = phase_new ? -clip_val : clip_val;
      sbs_pkg::MODE_INVERT: sub_clip = phase_new ? -dbl : dbl;
      default:              sub_clip = clip_val;
    endcase
  end

  // Table index from the phase; odd quadrants run the table backward.
  assign kprod = KPROD_W'(osc_angle[PHASE_W-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);
  assign kraw = kprod[KPROD_W-1:PHASE_W];
  assign k_sel = osc_angle[PHASE_W] ? IDX_W'(SINE_TABLE_DEPTH) - kraw : kraw;

  // Shared multiplier operand selection.
  always_comb begin
    opa = '0;
    opb = '0;
    mul_en = 1'b0;
    case (op)
      sbs_pkg::OP_P1_MUL: begin
        opa = OPA_W'(a_s) + OPA_W'(b_s) - OPA_W'(pre1);
        opb = OPB_W'(cfg.filter_coeff);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_P2_MUL: begin
        opa = OPA_W'(pre1) - OPA_W'(pre2);
        opb = OPB_W'(cfg.filter_coeff);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_ENV_MUL: begin
        opa = OPA_W'(envelope);
        opb = OPB_W'(cfg.decay);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_SIN_MUL: begin
        // The angle holds still for the whole item, so its sign bit lines up
        // with the registered ROM word.
        opa = osc_angle[PHASE_W+1] ? -OPA_W'(sine_word) : OPA_W'(sine_word);
        opb = OPB_W'(envelope);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_Q1_MUL: begin
        opa = sub - OPA_W'(post1);
        opb = OPB_W'(cfg.filter_coeff);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_Q2_MUL: begin
        opa = OPA_W'(post1) - OPA_W'(post2);
        opb = OPB_W'(cfg.filter_coeff);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_ML_DRY: begin
        opa = OPA_W'(a_s);
        opb = OPB_W'(cfg.dry_level);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_MR_DRY: begin
        opa = OPA_W'(b_s);
        opb = OPB_W'(cfg.dry_level);
        mul_en = 1'b1;
      end
      sbs_pkg::OP_ML_WET, sbs_pkg::OP_MR_WET: begin
        opa = OPA_W'(post2);
        opb = OPB_W'(cfg.wet_level);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul = opa * opb;
  assign sin_shifted = prod >>> SIN_SHIFT;

  // Payload registers.
  always_ff @(posedge clk) begin
    sine_idx <= k_sel;
    sine_word <= SINE_ROM[sine_idx];
    if (mul_en) begin
      prod <= mul;
    end
    case (op)
      sbs_pkg::OP_LOAD: begin
        a_s <= in_data.left_in;
        b_s <= in_data.right_in;
      end
      sbs_pkg::OP_CLIP:   sub <= sub_clip;
      sbs_pkg::OP_SIN_WB: sub <= sin_shifted[OPA_W-1:0];
      sbs_pkg::OP_ML_WET, sbs_pkg::OP_MR_WET: acc <= prod;
      sbs_pkg::OP_ML_WB:  left_res <= mix_sat(acc, prod);
      sbs_pkg::OP_MR_WB: begin
        out_data.left_out <= left_res;
        out_data.right_out <= mix_sat(acc, prod);
      end
      default: begin
      end
    endcase
  end

  // Filter, divider and oscillator state, and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pre1 <= '0;
      pre2 <= '0;
      post1 <= '0;
      post2 <= '0;
      div_sign <= 1'b0;
      div_phase <= 1'b0;
      osc_angle <= '0;
      envelope <= '0;
      out_valid <= 1'b0;
    end else begin
      case (op)
        sbs_pkg::OP_P1_WB: pre1 <= pole_update(pre1, prod);
        sbs_pkg::OP_P2_WB: pre2 <= pole_update(pre2, prod);
        sbs_pkg::OP_Q1_WB: post1 <= pole_update(post1, prod);
        sbs_pkg::OP_Q2_WB: post2 <= pole_update(post2, prod);
        sbs_pkg::OP_CLIP: begin
          div_sign <= sign_new;
          div_phase <= phase_new;
        end
        sbs_pkg::OP_ENV_WB: envelope <= gt ? 24'hFFFFFF : prod[47:24];
        sbs_pkg::OP_SIN_WB: osc_angle <= osc_angle + 24'(cfg.osc_step);
        default: begin
        end
      endcase
      if (op == sbs_pkg::OP_MR_WB) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/subharmonic_bass_synth_top.sv]
// Top level of the subharmonic bass synthesizer: configuration registers,
// controller and datapath. Depends on sbs_pkg, sbs_ctrl, sbs_datapath and
// the assertion macro header.

// The block takes one stereo sample request (left_in, right_in, signed Q1.23)
// and returns one mixed stereo request per input. The sum of both channels
// runs through two one-pole low-pass stages, is shaped according to the mode
// register (threshold clip, octave divider, doubled and phase-flipped signal,
// or a keyed sine oscillator with an exponential envelope), is smoothed by two
// more one-pole stages and is then mixed into each channel with the wet and dry
// gains and saturated. Every product of the item goes through one shared
// multiplier, issued in a multiply state and written back in the state that
// follows it. The result enters the output register at the last step, which in
// mode 3 comes later, as the envelope and sine products take three more steps
// than the clip. The next request is taken only once the controller is back
// in its idle state, so the block takes no new item before the last one is
// done. The input is stalled while an item is in flight; the result waits in
// the output register, and only if the previous result has not been taken by
// then does the last step wait for it. Configuration writes take effect at the
// next edge and are meant to happen only while the block is idle; a write to
// an index beyond the register list is ignored. After reset the filter stages,
// divider, oscillator phase and envelope are zero and no warm-up time is
// needed; the sine table is a constant ROM with a registered read.
`include "subharmonic_bass_synth_top_macros.svh"

module subharmonic_bass_synth_top #(
  parameter int SINE_TABLE_DEPTH = sbs_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sbs_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sbs_pkg::out_t                      out_data,
  input  logic                               wr_en,
  input  logic [sbs_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [sbs_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  sbs_pkg::cfg_t  cfg;
  sbs_pkg::op_t   op;
  sbs_pkg::stat_t stat;
  logic           idle;
  logic           accept_in;
  logic           load_op;
  logic           final_op;

  // Configuration registers, written one at a time by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= sbs_pkg::MODE_DISTORT;
      cfg.filter_coeff <= sbs_pkg::RST_FILTER_COEFF;
      cfg.osc_step <= sbs_pkg::RST_OSC_STEP;
      cfg.threshold <= sbs_pkg::RST_THRESHOLD;
      cfg.decay <= sbs_pkg::RST_DECAY;
      cfg.wet_level <= sbs_pkg::RST_WET_LEVEL;
      cfg.dry_level <= sbs_pkg::RST_DRY_LEVEL;
    end else if (wr_en) begin
      case (wr_index)
        sbs_pkg::REG_MODE:         cfg.mode <= sbs_pkg::mode_t'(wr_data[1:0]);
        sbs_pkg::REG_FILTER_COEFF: cfg.filter_coeff <= wr_data[15:0];
        sbs_pkg::REG_OSC_STEP:     cfg.osc_step <= wr_data[17:0];
        sbs_pkg::REG_THRESHOLD:    cfg.threshold <= wr_data[23:0];
        sbs_pkg::REG_DECAY:        cfg.decay <= wr_data[23:0];
        sbs_pkg::REG_WET_LEVEL:    cfg.wet_level <= wr_data[15:0];
        sbs_pkg::REG_DRY_LEVEL:    cfg.dry_level <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // A new request is taken only while the controller waits in its idle state.
  assign in_stall = !idle;

  sbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .op       (op),
    .idle     (idle)
  );

  sbs_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  // Short names for the events that the checks below look at.
  assign accept_in = in_valid && !in_stall;
  assign load_op = (op == sbs_pkg::OP_LOAD);
  assign final_op = (op == sbs_pkg::OP_MR_WB);

  // The input registers load exactly on an accepted request.
  `SBS_ASSERT_IMPLY(a_load_on_accept, clk, rst, load_op, accept_in, "load without a request")
  // Once a request is taken the block must stall the input for the next cycle.
  `SBS_ASSERT_NEXT(a_stall_after_accept, clk, rst, accept_in, in_stall, "no stall in flight")
  // The final write never overwrites a result that is still being held.
  `SBS_ASSERT_IMPLY(a_result_slot_free, clk, rst, final_op, !stat.out_busy, "result overwritten")
  // A completed item shows up as a valid output in the next cycle.
  `SBS_ASSERT_NEXT(a_result_presented, clk, rst, final_op, out_valid, "result not presented")

endmodule

[verif/testbench.sv]
// Self-checking testbench for the subharmonic bass synthesizer top level.
// Depends on sbs_pkg and subharmonic_bass_synth_top; predicts every mixed
// stereo request in fixed point and compares it with what the block returns.
module testbench;
  import sbs_pkg::*;

  // Handshake and run-length knobs.
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_PHASES  = 14;

  // Index just past the register list; writes there must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  localparam longint SINE_DEPTH = SINE_TABLE_DEPTH_DEFAULT;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {FRAC_BITS{1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {FRAC_BITS{1'b0}}};
  localparam longint SAT_HI = (64'sd1 <<< FRAC_BITS) - 64'sd1;
  localparam longint SAT_LO = -(64'sd1 <<< FRAC_BITS);

  // Every input of the block starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] wr_index = '0;
  logic [CFG_DATA_BITS-1:0]  wr_data = '0;

  subharmonic_bass_synth_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always #5 clk = ~clk;

  // Mixed pairs the block still owes us, oldest first.
  out_t expected_mix[$];
  int   mismatches = 0;

  // When calm is set, neither side inserts idle cycles any more.
  bit   calm = 1'b0;
  // The sender bumps hold_requests; the receiver answers each with a long stall.
  int   hold_requests = 0;
  // Tracks whether in_valid is currently being driven high.
  bit   offering = 1'b0;

  // Shadow of the configuration registers and of the signal path state.
  cfg_t      cfg_model = '{mode: MODE_DISTORT, filter_coeff: RST_FILTER_COEFF,
                           osc_step: RST_OSC_STEP, threshold: RST_THRESHOLD,
                           decay: RST_DECAY, wet_level: RST_WET_LEVEL,
                           dry_level: RST_DRY_LEVEL};
  int        lp_pre1 = 0, lp_pre2 = 0, lp_post1 = 0, lp_post2 = 0;
  bit        div_neg = 1'b0, div_flip = 1'b0;
  bit [23:0] osc_phase = '0, env_level = '0;

  // State of the random sample shaper: bursts of a held level with jitter,
  // alternating in sign, broken up now and then by bursts of raw noise.
  int burst_left = 0;
  int burst_level = 0;
  bit burst_neg = 1'b0;
  bit noise_burst = 1'b0;

  // One-pole low-pass stage with rounding and 32-bit saturation.
  function automatic int lowpass(int y, longint x);
    longint d, s;
    d = x - longint'(y);
    s = longint'(y) + ((d * longint'(cfg_model.filter_coeff) + 64'sd32768) >>> 16);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return int'(s);
  endfunction

  // Quarter-wave sine entry k in Q30, odd polynomial evaluated by Horner.
  function automatic longint quarter_wave(longint k);
    longint x, x2, r;
    x  = (k <<< 30) / SINE_DEPTH;
    x2 = (x * x) >>> 30;
    r  = 64'sd172272;
    r  = -64'sd5026995 + ((r * x2) >>> 30);
    r  = 64'sd85569305 + ((r * x2) >>> 30);
    r  = -64'sd693598668 + ((r * x2) >>> 30);
    r  = 64'sd1686629713 + ((r * x2) >>> 30);
    return (r * x) >>> 30;
  endfunction

  function automatic longint sine_q30(bit [23:0] angle);
    longint k, s;
    k = (longint'(angle[21:0]) * SINE_DEPTH) >>> 22;
    if (angle[22]) k = SINE_DEPTH - k;
    s = quarter_wave(k);
    return angle[23] ? -s : s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] mix_channel(longint x, longint sub);
    longint v;
    v = (x * longint'(cfg_model.dry_level) + sub * longint'(cfg_model.wet_level)
         + 64'sd16384) >>> 15;
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Advances the shadow state by one stereo pair and returns the mixed pair.
  function automatic out_t predict_mix(in_t s);
    longint a, b, thr, sub, unity;
    out_t   r;
    a     = longint'($signed(s.left_in));
    b     = longint'($signed(s.right_in));
    thr   = longint'(cfg_model.threshold);
    unity = 64'sd1 <<< FRAC_BITS;
    sub   = 0;

    lp_pre1 = lowpass(lp_pre1, a + b);
    lp_pre2 = lowpass(lp_pre2, longint'(lp_pre1));

    if (cfg_model.mode != MODE_OSC) begin
      if (longint'(lp_pre2) > thr) sub = unity;
      else if (longint'(lp_pre2) < -thr) sub = -unity;
      // The divider flips its sign on every change of clip polarity and its
      // phase on every change toward negative.
      if (sub != 0 && ((sub < 0) != div_neg)) begin
        div_neg = !div_neg;
        if (div_neg) div_flip = !div_flip;
      end
      if (cfg_model.mode == MODE_DIVIDE && div_flip) sub = -sub;
      if (cfg_model.mode == MODE_INVERT) begin
        sub = div_flip ? -2 * longint'(lp_pre2) : 2 * longint'(lp_pre2);
      end
    end else begin
      if (longint'(lp_pre2) > thr) env_level = 24'hFFFFFF;
      else env_level = 24'((longint'(env_level) * longint'(cfg_model.decay)) >>> 24);
      sub = (longint'(env_level) * sine_q30(osc_phase)) >>> (54 - FRAC_BITS);
      osc_phase = osc_phase + cfg_model.osc_step;
    end

    lp_post1 = lowpass(lp_post1, sub);
    lp_post2 = lowpass(lp_post2, longint'(lp_post1));

    r.left_out  = mix_channel(a, longint'(lp_post2));
    r.right_out = mix_channel(b, longint'(lp_post2));
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(int v);
    if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < int'(SAMPLE_MIN)) return SAMPLE_MIN;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic in_t next_sample();
    in_t s;
    int  mag;
    if (burst_left == 0) begin
      noise_burst = ($urandom_range(0, 4) == 0);
      burst_left  = noise_burst ? $urandom_range(1, 10) : $urandom_range(8, 80);
      mag         = $urandom_range(100000, 8388607);
      burst_neg   = !burst_neg;
      burst_level = burst_neg ? -mag : mag;
    end
    burst_left--;
    if (noise_burst) begin
      s.left_in  = SAMPLE_BITS'($urandom);
      s.right_in = SAMPLE_BITS'($urandom);
    end else begin
      s.left_in  = clamp_sample(burst_level + int'($urandom_range(0, 131072)) - 65536);
      s.right_in = clamp_sample(burst_level + int'($urandom_range(0, 131072)) - 65536);
    end
    return s;
  endfunction

  // Picks an endpoint a quarter of the time each, otherwise anything between.
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Offers one sample request and returns at the edge where it is accepted.
  // The prediction is queued at that same edge.
  task automatic send_sample(input in_t s);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_mix.push_back(predict_mix(s));
  endtask

  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    in_t s;
    s.left_in  = l;
    s.right_in = r;
    send_sample(s);
  endtask

  // Stops offering and waits until every owed result has been taken, so the
  // block is idle and registers may be written.
  task automatic wait_drained();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (expected_mix.size() != 0) @(posedge clk);
  endtask

  // Leaves wr_en high; the caller lowers it after its last write.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    case (idx)
      REG_MODE:         cfg_model.mode         = mode_t'(value[1:0]);
      REG_FILTER_COEFF: cfg_model.filter_coeff = value[15:0];
      REG_OSC_STEP:     cfg_model.osc_step     = value[17:0];
      REG_THRESHOLD:    cfg_model.threshold    = value[23:0];
      REG_DECAY:        cfg_model.decay        = value[23:0];
      REG_WET_LEVEL:    cfg_model.wet_level    = value[15:0];
      REG_DRY_LEVEL:    cfg_model.dry_level    = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_register(REG_MODE, CFG_DATA_BITS'(c.mode));
    write_register(REG_FILTER_COEFF, CFG_DATA_BITS'(c.filter_coeff));
    write_register(REG_OSC_STEP, CFG_DATA_BITS'(c.osc_step));
    write_register(REG_THRESHOLD, CFG_DATA_BITS'(c.threshold));
    write_register(REG_DECAY, CFG_DATA_BITS'(c.decay));
    write_register(REG_WET_LEVEL, CFG_DATA_BITS'(c.wet_level));
    write_register(REG_DRY_LEVEL, CFG_DATA_BITS'(c.dry_level));
    wr_en <= 1'b0;
  endtask

  // A few requests straight out of reset, with the field extremes.
  task automatic test_reset_settings();
    send_pair('0, '0);
    send_pair(SAMPLE_MAX, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MIN);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
  endtask

  // Each mode with a nearly transparent filter, so that the clip, both
  // divider flips and the envelope keying all show up within a few requests.
  // A write to the unused index sits in the middle and must change nothing.
  task automatic test_mode_shapes();
    cfg_t c;
    mode_t m;
    c = '{mode: MODE_DISTORT, filter_coeff: 16'hFFFF, osc_step: 18'd200000,
          threshold: 24'd1000000, decay: 24'd16700000, wet_level: 16'd32768,
          dry_level: 16'd16384};
    wait_drained();
    apply_settings(c);
    m = MODE_DISTORT;
    repeat (4) begin
      wait_drained();
      write_register(REG_MODE, CFG_DATA_BITS'(m));
      if (m == MODE_INVERT) write_register(REG_UNUSED, 24'hFFFFFF);
      wr_en <= 1'b0;
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair(SAMPLE_MIN, SAMPLE_MIN);
      send_pair(SAMPLE_MAX, SAMPLE_MAX);
      send_pair('0, '0);
      m = m.next();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the block fills up and stalls its input.
  task automatic test_output_backpressure();
    wait_drained();
    hold_requests++;
    repeat (40) send_sample(next_sample());
  endtask

  // The sender pauses in the middle until every result has come back.
  task automatic test_drain_pause();
    repeat (30) send_sample(next_sample());
    wait_drained();
    repeat (30) send_sample(next_sample());
  endtask

  // Several settings phases, all minimums first, then all maximums, then
  // gains above unity with a threshold above full scale, then random ones.
  task automatic test_random_phases();
    cfg_t c;
    int   n;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: c = '{mode: MODE_DISTORT, filter_coeff: 16'd1, osc_step: 18'd0,
                 threshold: 24'd0, decay: 24'd16609444, wet_level: 16'd0,
                 dry_level: 16'd0};
        1: c = '{mode: MODE_OSC, filter_coeff: 16'hFFFF, osc_step: 18'h3FFFF,
                 threshold: 24'd8388608, decay: 24'hFFFFFF, wet_level: 16'd32768,
                 dry_level: 16'd32768};
        2: c = '{mode: MODE_INVERT, filter_coeff: 16'd40000, osc_step: 18'd1000,
                 threshold: 24'hFFFFFF, decay: 24'd16700000, wet_level: 16'hFFFF,
                 dry_level: 16'hFFFF};
        default: begin
          c.mode = mode_t'(2'(phase % 4));
          case ($urandom_range(0, 3))
            0: c.filter_coeff = 16'd1;
            1: c.filter_coeff = 16'hFFFF;
            2: c.filter_coeff = RST_FILTER_COEFF;
            default: c.filter_coeff = 16'($urandom_range(65535, 200));
          endcase
          c.osc_step  = 18'(pick_value(0, 262143));
          c.threshold = ($urandom_range(0, 2) == 0) ? 24'(pick_value(0, 8388608))
                                                    : 24'($urandom_range(3000000, 0));
          c.decay     = 24'(pick_value(16609444, 16777215));
          c.wet_level = 16'(pick_value(0, 32768));
          c.dry_level = 16'(pick_value(0, 32768));
        end
      endcase
      wait_drained();
      apply_settings(c);
      n = $urandom_range(60, 100);
      repeat (n) send_sample(next_sample());
    end
  endtask

  // Last part: reset settings but in oscillator mode, and a gap-free stream on both sides.
  task automatic test_steady_stream();
    cfg_t c;
    c = '{mode: MODE_OSC, filter_coeff: RST_FILTER_COEFF, osc_step: RST_OSC_STEP,
          threshold: RST_THRESHOLD, decay: RST_DECAY, wet_level: RST_WET_LEVEL,
          dry_level: RST_DRY_LEVEL};
    wait_drained();
    apply_settings(c);
    calm = 1'b1;
    repeat (200) send_sample(next_sample());
  endtask

  // Receiver: random stall bursts, and one long hold
  // for every hold request. Its stall is counted here, not in the sender.
  initial begin : receiver
    int stall_left;
    int holds_served;
    stall_left   = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        $display("%0t: result with nothing expected, left=%0d right=%0d", $time,
                 $signed(out_data.left_out), $signed(out_data.right_out));
        mismatches++;
      end else begin
        want = expected_mix.pop_front();
        if (want.left_out !== out_data.left_out) begin
          $display("%0t: left_out expected %0d actual %0d", $time,
                   $signed(want.left_out), $signed(out_data.left_out));
          mismatches++;
        end
        if (want.right_out !== out_data.right_out) begin
          $display("%0t: right_out expected %0d actual %0d", $time,
                   $signed(want.right_out), $signed(out_data.right_out));
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no request moving on any port
  // means the block has hung.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
      $display("FAIL subharmonic_bass_synth_top");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_mode_shapes();
    test_output_backpressure();
    test_drain_pause();
    test_random_phases();
    test_steady_stream();

    wait_drained();
    // Give the block time to show any stray result before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("PASS subharmonic_bass_synth_top");
    end else begin
      $display("FAIL subharmonic_bass_synth_top");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_ctrl.sv
hw/rtl/sbs_datapath.sv
hw/rtl/subharmonic_bass_synth_top.sv
verif/testbench.sv
